// ----- design/ocu_pkg.sv -----
// Orbit camera update: shared types, constants and the sine table.
// No dependencies; imported by ocu_trig, ocu_div, orbit_camera_update and the dv files.
`default_nettype none
package ocu_pkg;

  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int SINE_IDX_W = $clog2(SINE_TABLE_ENTRIES);

  // angles are Q9.8 degrees
  localparam logic [16:0] TURN_Q8    = 17'd92160;
  localparam logic [16:0] QUARTER_Q8 = 17'd23040;
  localparam logic signed [16:0] PITCH_LIMIT = 17'sd22784;
  localparam logic [31:0] DIST_FLOOR = 32'd32768;
  localparam logic [31:0] DIST_RESET = 32'd655360;
  localparam logic [31:0] DIST_CEIL  = 32'h7FFF_FFFF;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  // angle to table index: idx = angle * N / TURN, done as a reciprocal multiply
  localparam int IDX_SHIFT = 34;
  localparam logic [31:0] IDX_MUL = 32'(((64'(SINE_TABLE_ENTRIES) << IDX_SHIFT)
                                         + 64'(TURN_Q8) - 64'd1) / 64'(TURN_Q8));

  localparam logic [1:0] REG_PAN_SPEED  = 2'd0;
  localparam logic [1:0] REG_ZOOM_SPEED = 2'd1;
  localparam logic [1:0] REG_FOV        = 2'd2;
  localparam logic [1:0] REG_ORTHO      = 2'd3;

  typedef logic [16:0] angle_t;
  typedef logic signed [17:0] trig_t;
  typedef trig_t sine_rom_t [SINE_TABLE_ENTRIES];

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // quadrant folding and a Taylor series to x^13 in Q30, rounded to Q16
  function automatic sine_rom_t build_sine();
    sine_rom_t rom;
    logic [63:0] t, x, x2, term, v;
    logic signed [63:0] sum;
    logic neg;
    for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
      t = (64'(k) << 32) / SINE_TABLE_ENTRIES;
      neg = 1'b0;
      if (t >= 64'h8000_0000) begin
        neg = 1'b1;
        t = t - 64'h8000_0000;
      end
      if (t > 64'h4000_0000) t = 64'h8000_0000 - t;
      x = (t * TWO_PI_Q30) >> 32;
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed(x);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
      if (sum < 0) sum = '0;
      v = ($unsigned(sum) + 64'd8192) >> 14;
      rom[k] = neg ? -18'(v) : 18'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

endpackage
`default_nettype wire

// ----- design/ocu_in_if.sv -----
// Control tick channel: valid/ready handshake with the tick payload.
// Stand-alone; no package needed.
`default_nettype none
interface ocu_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] yaw_delta;
  logic signed [15:0] pitch_delta;
  logic signed [15:0] move_forward;
  logic signed [15:0] move_right;
  logic signed [15:0] move_up;
  logic signed [15:0] zoom_delta;
  logic [15:0] time_step;

  modport source (output valid, yaw_delta, pitch_delta, move_forward, move_right,
                  move_up, zoom_delta, time_step, input ready);
  modport sink (input valid, yaw_delta, pitch_delta, move_forward, move_right,
                move_up, zoom_delta, time_step, output ready);
endinterface
`default_nettype wire

// ----- design/ocu_out_if.sv -----
// Camera view channel: valid/ready handshake with the view payload.
// Stand-alone; no package needed.
`default_nettype none
interface ocu_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] look_x;
  logic signed [31:0] look_y;
  logic signed [31:0] look_z;
  logic [31:0] ortho_height;
  logic is_ortho;

  modport source (output valid, eye_x, eye_y, eye_z, look_x, look_y, look_z,
                  ortho_height, is_ortho, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, look_x, look_y, look_z,
                ortho_height, is_ortho, output ready);
endinterface
`default_nettype wire

// ----- design/ocu_trig.sv -----
// Sine/cosine lookup: the index multiply is registered, then the table read is registered.
// Depends on ocu_pkg (sine table, index reciprocal).
`default_nettype none
module ocu_trig (
  input  logic           clk,
  input  ocu_pkg::angle_t angle,
  input  logic           cos_sel,
  output ocu_pkg::trig_t value
);
  import ocu_pkg::*;

  logic [17:0] shifted;
  logic [17:0] wrapped;
  logic [48:0] prod;
  logic [14:0] idx_full;
  logic [SINE_IDX_W-1:0] idx;

  always_comb begin
    shifted = {1'b0, angle} + (cos_sel ? {1'b0, QUARTER_Q8} : 18'd0);
    wrapped = (shifted >= {1'b0, TURN_Q8}) ? shifted - {1'b0, TURN_Q8} : shifted;
    prod = 49'(wrapped[16:0]) * 49'(IDX_MUL);
    idx_full = prod[48:IDX_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (idx_full >= 15'(SINE_TABLE_ENTRIES)) idx <= SINE_IDX_W'(SINE_TABLE_ENTRIES - 1);
    else idx <= idx_full[SINE_IDX_W-1:0];
    value <= SINE_ROM[idx];
  end
endmodule
`default_nettype wire

// ----- design/ocu_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on nothing but the clock.
`default_nettype none
module ocu_mul (
  input  logic               clk,
  input  logic signed [33:0] a,
  input  logic signed [32:0] b,
  output logic signed [63:0] p
);
  logic signed [66:0] full;

  assign full = 67'(a) * 67'(b);

  always_ff @(posedge clk) begin
    p <= full[63:0];
  end
endmodule
`default_nettype wire

// ----- design/ocu_div.sv -----
// Restoring divider, one quotient bit a cycle, saturating 32-bit quotient.
// Depends on ocu_pkg (status struct).
`default_nettype none
module ocu_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [47:0]       num,
  input  logic [16:0]       den,
  output ocu_pkg::div_stat_t stat,
  output logic [31:0]       quot
);
  import ocu_pkg::*;

  logic [16:0] rem;
  logic [31:0] low;
  logic [5:0]  cnt;
  logic [17:0] trial;
  logic        fits;

  assign trial = {rem, low[31]};
  assign fits = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      if (start) begin
        if (num[47:32] >= den) begin
          quot <= '1;              // quotient would not fit in 32 bits
          stat.done <= 1'b1;
        end else begin
          rem <= {1'b0, num[47:32]};
          low <= num[31:0];
          cnt <= 6'd32;
          stat.busy <= 1'b1;
          stat.done <= 1'b0;
        end
      end else if (stat.busy) begin
        rem  <= fits ? 17'(trial - {1'b0, den}) : trial[16:0];
        quot <= {quot[30:0], fits};
        low  <= {low[30:0], 1'b0};
        cnt  <= cnt - 6'd1;
        stat.done <= (cnt == 6'd1);
        if (cnt == 6'd1) stat.busy <= 1'b0;
      end else begin
        stat.done <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ----- design/orbit_camera_update.sv -----
// Orbit camera update. Each transaction on ctl is one control tick: yaw and
// pitch deltas, pan amounts, zoom and the elapsed time. For each tick the block
// updates its heading, target and orbit distance and returns one transaction
// on view: eye position, target, orthographic height and projection flag.
// Registers (pan speed, zoom speed, field of view, ortho mode) are written on
// cfg_write_enable/cfg_index/cfg_data; the user must write them only while
// the block is idle, which the block itself does not enforce. One tick at a
// time: ctl.ready is high only while idle. A tick runs 15 sequencer steps on
// the shared multiplier, then a restoring divide; then the quotient is taken
// and the output register loaded. The divide is skipped and the height set to
// all ones when the half field of view is at or past 90 degrees, and the
// divider saturates at once when the height would not fit. The next tick is
// taken once the block is back in idle; the divide takes most of a tick.
// The output register holds a result until view.ready; a new tick may be
// accepted meanwhile, and its result waits in ST_FIN for the slot.
// Synchronous reset restores the register defaults, zero heading, distance
// 10.0 and target at the origin, and empties the output.
`default_nettype none
module orbit_camera_update (
  input  logic        clk,
  input  logic        rst,
  ocu_in_if.sink      ctl,
  ocu_out_if.source   view,
  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ocu_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;
  localparam logic [3:0] LAST_STEP = 4'd14;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -32'sh8000_0000;
    return v[31:0];
  endfunction

  logic [1:0] state;
  logic [3:0] step;

  logic [15:0] pan_speed, zoom_speed, field_of_view;
  logic        ortho_mode;

  angle_t yaw;
  logic signed [15:0] pitch;
  logic [31:0] orbit_dist;
  logic signed [31:0] tx, ty, tz;

  logic signed [15:0] zd, mf, mr, mu;
  logic [15:0] ts;
  logic [31:0] pan;
  logic signed [25:0] f, r;
  logic signed [63:0] acc;
  trig_t sy, cy, sp, cp, sh, ch;
  logic signed [33:0] dcp;
  logic signed [31:0] ex, ey, ez;
  logic [31:0] height;

  logic signed [18:0] yv;
  logic signed [16:0] pv;
  angle_t yaw_next, pa, half;
  logic signed [15:0] pitch_next;
  logic signed [63:0] dsum;

  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [63:0] prod;
  angle_t trig_angle;
  logic   trig_cos;
  trig_t  trig_val;

  logic      div_start;
  div_stat_t div_stat;
  logic [31:0] quot;

  logic accept;
  logic load_view;

  assign ctl.ready = (state == ST_IDLE);
  assign accept = ctl.valid && ctl.ready;
  assign load_view = (state == ST_FIN) && (!view.valid || view.ready);

  always_comb begin
    yv = $signed({2'b00, yaw}) + 19'(ctl.yaw_delta);
    if (yv < 0) yv = yv + $signed({2'b00, TURN_Q8});
    else if (yv >= $signed({2'b00, TURN_Q8})) yv = yv - $signed({2'b00, TURN_Q8});
    yaw_next = yv[16:0];
    pv = 17'(pitch) + 17'(ctl.pitch_delta);
    if (pv > PITCH_LIMIT) pv = PITCH_LIMIT;
    if (pv < -PITCH_LIMIT) pv = -PITCH_LIMIT;
    pitch_next = pv[15:0];
    pa = pitch[15] ? 17'(17'(pitch) + TURN_Q8) : 17'(pitch);
    half = {2'b00, field_of_view[15:1]};
    dsum = $signed({32'd0, orbit_dist}) - prod;
  end

  // trig lookups issued in steps 0..5, each value taken once it has passed the index and table registers of ocu_trig
  always_comb begin
    trig_angle = yaw;
    trig_cos = 1'b0;
    case (step)
      4'd1: trig_cos = 1'b1;
      4'd2: trig_angle = pa;
      4'd3: begin
        trig_angle = pa;
        trig_cos = 1'b1;
      end
      4'd4: trig_angle = half;
      4'd5: begin
        trig_angle = half;
        trig_cos = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      4'd0: begin
        mul_a = 34'(pan_speed);
        mul_b = 33'(ts);
      end
      4'd1: begin
        mul_a = 34'(zd);
        mul_b = 33'(zoom_speed);
      end
      4'd2: begin
        mul_a = 34'(mf);
        mul_b = 33'(pan);
      end
      4'd3: begin
        mul_a = 34'(mr);
        mul_b = 33'(pan);
      end
      4'd4: begin
        mul_a = 34'(mu);
        mul_b = 33'(pan);
      end
      4'd5: begin
        mul_a = 34'(f);
        mul_b = 33'(sy);
      end
      4'd6: begin
        mul_a = 34'(r);
        mul_b = 33'(cy);
      end
      4'd7: begin
        mul_a = 34'(f);
        mul_b = 33'(cy);
      end
      4'd8: begin
        mul_a = 34'(r);
        mul_b = 33'(sy);
      end
      4'd9: begin
        mul_a = 34'(orbit_dist);
        mul_b = 33'(cp);
      end
      4'd10: begin
        mul_a = 34'(orbit_dist);
        mul_b = 33'(sp);
      end
      4'd11: begin
        mul_a = dcp;
        mul_b = 33'(sy);
      end
      4'd12: begin
        mul_a = dcp;
        mul_b = 33'(cy);
      end
      4'd13: begin
        mul_a = 34'(orbit_dist);
        mul_b = 33'(sh);
      end
      default: ;
    endcase
  end

  assign div_start = (state == ST_RUN) && (step == LAST_STEP) && (ch > 0);

  ocu_trig u_trig (
    .clk     (clk),
    .angle   (trig_angle),
    .cos_sel (trig_cos),
    .value   (trig_val)
  );

  ocu_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  ocu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({prod[46:0], 1'b0}),
    .den   (ch[16:0]),
    .stat  (div_stat),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_speed     <= 16'd1280;
      zoom_speed    <= 16'd256;
      field_of_view <= 16'd15360;
      ortho_mode    <= 1'b0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_PAN_SPEED:  pan_speed <= cfg_data;
        REG_ZOOM_SPEED: zoom_speed <= cfg_data;
        REG_FOV:        field_of_view <= cfg_data;
        REG_ORTHO:      ortho_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      yaw   <= '0;
      pitch <= '0;
      orbit_dist <= DIST_RESET;
      tx    <= '0;
      ty    <= '0;
      tz    <= '0;
      view.valid <= 1'b0;
    end else begin
      if (load_view) view.valid <= 1'b1;
      else if (view.valid && view.ready) view.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          step <= '0;
          if (accept) begin
            yaw   <= yaw_next;
            pitch <= pitch_next;
            zd <= ctl.zoom_delta;
            mf <= ctl.move_forward;
            mr <= ctl.move_right;
            mu <= ctl.move_up;
            ts <= ctl.time_step;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          step <= step + 4'd1;
          // each step takes the product issued in the step before
          case (step)
            4'd1: pan <= prod[31:0];
            4'd2: begin
              if (dsum < $signed({32'd0, DIST_FLOOR})) orbit_dist <= DIST_FLOOR;
              else if (dsum > $signed({32'd0, DIST_CEIL})) orbit_dist <= DIST_CEIL;
              else orbit_dist <= dsum[31:0];
              sy <= trig_val;
            end
            4'd3: begin
              f  <= 26'(prod >>> 22);
              cy <= trig_val;
            end
            4'd4: begin
              r  <= 26'(prod >>> 22);
              sp <= trig_val;
            end
            4'd5: begin
              ty <= sat32(64'(ty) + (prod >>> 22));
              cp <= trig_val;
            end
            4'd6: begin
              acc <= -prod;
              sh  <= trig_val[17] ? '0 : trig_val;
            end
            4'd7: begin
              tx <= sat32(64'(tx) + ((acc + prod) >>> 16));
              ch <= trig_val;
            end
            4'd8: acc <= -prod;
            4'd9: tz <= sat32(64'(tz) + ((acc - prod) >>> 16));
            4'd10: dcp <= 34'(prod >>> 16);
            4'd11: ey <= sat32(64'(ty) + (prod >>> 16));
            4'd12: ex <= sat32(64'(tx) + (prod >>> 16));
            4'd13: ez <= sat32(64'(tz) + (prod >>> 16));
            LAST_STEP: begin
              if (ch > 0) begin
                state <= ST_DIV;
              end else begin
                height <= '1;
                state <= ST_FIN;
              end
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          if (div_stat.done) begin
            height <= quot;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (load_view) begin
            view.eye_x <= ex;
            view.eye_y <= ey;
            view.eye_z <= ez;
            view.look_x <= tx;
            view.look_y <= ty;
            view.look_z <= tz;
            view.ortho_height <= height;
            view.is_ortho <= ortho_mode;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    orbit_dist >= DIST_FLOOR && orbit_dist <= DIST_CEIL)
    else $error("orbit distance out of range");
  a_yaw_range: assert property (@(posedge clk) disable iff (rst) yaw < TURN_Q8)
    else $error("yaw not wrapped");
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    17'(pitch) <= PITCH_LIMIT && 17'(pitch) >= -PITCH_LIMIT)
    else $error("pitch not clamped");
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> state == ST_DIV)
    else $error("divider busy outside divide phase");
`endif

endmodule
`default_nettype wire

// ----- dv/ocu_view_checker.sv -----
// Orbit camera update checker: watches the tick, view and register ports,
// predicts each view from its own camera model and compares field by field.
// Depends on ocu_pkg (register indexes) and the ocu_in_if/ocu_out_if interfaces.
module ocu_view_checker (
  input  logic        clk,
  input  logic        rst,
  ocu_in_if           ctl,
  ocu_out_if          view,
  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          views_awaited,
  output int          views_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import ocu_pkg::*;

  localparam int TABLE_N = 1024;
  localparam longint FULL_TURN = 92160;
  localparam longint QUARTER_TURN = 23040;
  localparam longint PITCH_MAX = 22784;
  localparam longint RANGE_MIN = 30'sd32768;
  localparam longint RANGE_TOP = 64'sd2147483647;

  typedef struct {
    longint eye_x, eye_y, eye_z, look_x, look_y, look_z;
    longint height;
    bit     ortho;
  } camera_view_t;

  longint sine_table [TABLE_N];

  bit [15:0] pan_rate, zoom_rate, fov_deg;
  bit        ortho_sel;
  longint    heading, tilt, radius;
  longint    target [3];

  camera_view_t expected_views [$];

  // Taylor series in Q30 over the first quadrant, folded, rounded to Q16
  function automatic void fill_sine_table();
    longint unsigned phase, x, x_sq, term;
    longint acc;
    bit lower_half;
    for (int k = 0; k < TABLE_N; k++) begin
      phase = (longint'(k) << 32) / TABLE_N;
      lower_half = phase >= 64'h8000_0000;
      if (lower_half) phase -= 64'h8000_0000;
      if (phase > 64'h4000_0000) phase = 64'h8000_0000 - phase;
      x = (phase * 64'd6746518852) >> 32;
      x_sq = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
        acc = (n % 2) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      acc = (acc + 8192) >>> 14;
      sine_table[k] = lower_half ? -acc : acc;
    end
  endfunction

  function automatic longint sin_deg(longint a);
    longint idx;
    idx = (a * TABLE_N) / FULL_TURN;
    if (idx >= TABLE_N) idx = TABLE_N - 1;
    return sine_table[idx];
  endfunction

  function automatic longint cos_deg(longint a);
    longint b;
    b = a + QUARTER_TURN;
    if (b >= FULL_TURN) b -= FULL_TURN;
    return sin_deg(b);
  endfunction

  function automatic longint sat32(longint v);
    if (v > RANGE_TOP) return RANGE_TOP;
    if (v < -RANGE_TOP - 1) return -RANGE_TOP - 1;
    return v;
  endfunction

  // advances the camera by one tick and returns the view it produces
  function automatic camera_view_t advance_camera(longint yd, longint pd, longint mf,
                                                  longint mr, longint mu, longint zd,
                                                  longint ts);
    camera_view_t v;
    longint sy, cy, sp, cp, pan, fwd, rgt, up, dcp, pa, sh, ch, h;
    heading += yd;
    if (heading < 0) heading += FULL_TURN;
    if (heading >= FULL_TURN) heading -= FULL_TURN;
    tilt += pd;
    if (tilt > PITCH_MAX) tilt = PITCH_MAX;
    if (tilt < -PITCH_MAX) tilt = -PITCH_MAX;
    sy = sin_deg(heading);
    cy = cos_deg(heading);
    pan = longint'(pan_rate) * ts;
    fwd = (mf * pan) >>> 22;
    rgt = (mr * pan) >>> 22;
    up  = (mu * pan) >>> 22;
    target[0] = sat32(target[0] + ((-fwd * sy + rgt * cy) >>> 16));
    target[1] = sat32(target[1] + up);
    target[2] = sat32(target[2] + ((-fwd * cy - rgt * sy) >>> 16));
    radius -= zd * longint'(zoom_rate);
    if (radius < RANGE_MIN) radius = RANGE_MIN;
    if (radius > RANGE_TOP) radius = RANGE_TOP;
    pa = (tilt < 0) ? tilt + FULL_TURN : tilt;
    sp = sin_deg(pa);
    cp = cos_deg(pa);
    dcp = (radius * cp) >>> 16;
    v.eye_x = sat32(target[0] + ((dcp * sy) >>> 16));
    v.eye_y = sat32(target[1] + ((radius * sp) >>> 16));
    v.eye_z = sat32(target[2] + ((dcp * cy) >>> 16));
    v.look_x = target[0];
    v.look_y = target[1];
    v.look_z = target[2];
    sh = sin_deg(fov_deg >> 1);
    ch = cos_deg(fov_deg >> 1);
    if (sh < 0) sh = 0;
    if (ch <= 0) h = 64'hFFFF_FFFF;
    else begin
      h = (2 * radius * sh) / ch;
      if (h > 64'hFFFF_FFFF) h = 64'hFFFF_FFFF;
    end
    v.height = h;
    v.ortho = ortho_sel;
    return v;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("[%0t] view mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  task automatic compare_view(camera_view_t w);
    if (longint'(view.eye_x) != w.eye_x) report_mismatch("eye_x", view.eye_x, w.eye_x);
    if (longint'(view.eye_y) != w.eye_y) report_mismatch("eye_y", view.eye_y, w.eye_y);
    if (longint'(view.eye_z) != w.eye_z) report_mismatch("eye_z", view.eye_z, w.eye_z);
    if (longint'(view.look_x) != w.look_x) report_mismatch("look_x", view.look_x, w.look_x);
    if (longint'(view.look_y) != w.look_y) report_mismatch("look_y", view.look_y, w.look_y);
    if (longint'(view.look_z) != w.look_z) report_mismatch("look_z", view.look_z, w.look_z);
    if (longint'(view.ortho_height) != w.height)
      report_mismatch("ortho_height", view.ortho_height, w.height);
    if (view.is_ortho !== w.ortho) report_mismatch("is_ortho", view.is_ortho, w.ortho);
  endtask

  initial begin
    mismatches = 0;
    views_checked = 0;
    fill_sine_table();
  end

  assign views_awaited = expected_views.size();

  always @(posedge clk) begin
    if (rst) begin
      pan_rate = 16'd1280;
      zoom_rate = 16'd256;
      fov_deg = 16'd15360;
      ortho_sel = 1'b0;
      heading = 0;
      tilt = 0;
      radius = 655360;
      target = '{0, 0, 0};
      expected_views.delete();
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          REG_PAN_SPEED:  pan_rate = cfg_data;
          REG_ZOOM_SPEED: zoom_rate = cfg_data;
          REG_FOV:        fov_deg = cfg_data;
          REG_ORTHO:      ortho_sel = cfg_data[0];
          default: ;
        endcase
      end
      // retire first, so a view and a tick on one edge stay in order
      if (view.valid && view.ready) begin
        if (expected_views.size() == 0) begin
          $display("[%0t] view transaction with nothing outstanding", $time);
          mismatches++;
        end else begin
          compare_view(expected_views.pop_front());
          views_checked++;
        end
      end
      if (ctl.valid && ctl.ready)
        expected_views.push_back(advance_camera(ctl.yaw_delta, ctl.pitch_delta,
            ctl.move_forward, ctl.move_right, ctl.move_up, ctl.zoom_delta,
            longint'(ctl.time_step)));
    end
  end
endmodule

// ----- dv/tb_orbit_camera_update.sv -----
// Testbench top for orbit_camera_update: clock, reset, tick and register stimulus,
// view back-pressure, watchdog and verdict. Depends on ocu_pkg, the two channel
// interfaces, the block itself and ocu_view_checker.
module tb_orbit_camera_update;
  timeunit 1ns;
  timeprecision 1ps;
  import ocu_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic [1:0]  cfg_index = REG_PAN_SPEED;
  logic [15:0] cfg_data = '0;
  int          mismatches, views_awaited, views_checked;
  int          ticks_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;

  ocu_in_if  ctl();
  ocu_out_if view();

  orbit_camera_update i_dut (
    .clk(clk), .rst(rst), .ctl(ctl), .view(view),
    .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ocu_view_checker i_checker (
    .clk(clk), .rst(rst), .ctl(ctl), .view(view),
    .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .views_awaited(views_awaited), .views_checked(views_checked)
  );

  always #4 clk = ~clk;

  initial begin
    ctl.valid = 1'b0;
    {ctl.yaw_delta, ctl.pitch_delta, ctl.move_forward, ctl.move_right} = '0;
    {ctl.move_up, ctl.zoom_delta, ctl.time_step} = '0;
    view.ready = 1'b0;
  end

  // back-pressure: a random stall style is held for a random span, then drawn anew
  int stall_style = 0, style_left = 0;
  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 3);
      style_left = $urandom_range(50, 400);
    end
    style_left--;
    case (stall_style)
      0: view.ready <= 1'b1;
      1: view.ready <= $urandom_range(0, 1);
      2: view.ready <= ($urandom_range(0, 7) == 0);
      default: view.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((ctl.valid && ctl.ready) || (view.valid && view.ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_write_enable = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write_enable = 1'b0;
  endtask

  task automatic set_camera_regs(logic [15:0] pan, logic [15:0] zoom, logic [15:0] fov,
                                 logic ortho);
    write_reg(REG_PAN_SPEED, pan);
    write_reg(REG_ZOOM_SPEED, zoom);
    write_reg(REG_FOV, fov);
    write_reg(REG_ORTHO, {15'd0, ortho});
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_tick(int yd, int pd, int mf, int mr, int mu, int zd, int ts);
    if (burst_left == 0) begin
      ctl.valid = 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 20) : 0) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    ctl.yaw_delta = 16'(yd);
    ctl.pitch_delta = 16'(pd);
    ctl.move_forward = 16'(mf);
    ctl.move_right = 16'(mr);
    ctl.move_up = 16'(mu);
    ctl.zoom_delta = 16'(zd);
    ctl.time_step = 16'(ts);
    ctl.valid = 1'b1;
    while (!ctl.ready) @(negedge clk);
    @(negedge clk);
    burst_left--;
    ticks_sent++;
  endtask

  function automatic int any16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int any_move();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  task automatic random_ticks(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7)
        // ordinary steering: modest turns and zooms keep the camera in range
        send_tick(int'($urandom_range(0, 2048)) - 1024, int'($urandom_range(0, 1024)) - 512,
                  any_move(), any_move(), any_move(),
                  int'($urandom_range(0, 512)) - 256, $urandom_range(0, 4096));
      else
        send_tick(any16(), any16(), any_move(), any_move(), any_move(), any16(),
                  $urandom_range(0, 65535));
    end
  endtask

  task automatic drain();
    ctl.valid = 1'b0;
    burst_left = 0;
    while (views_awaited != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed ticks at reset settings
    send_tick(0, 0, 0, 0, 0, 0, 0);
    send_tick(32767, 0, 0, 0, 0, 0, 0);
    send_tick(-32768, 0, 0, 0, 0, 0, 0);
    send_tick(0, 32767, 0, 0, 0, 0, 0);        // pitch clamps at the top
    send_tick(0, -32768, 0, 0, 0, 0, 0);       // and moves back down, short of the bottom clamp
    send_tick(23040, 22784, 0, 0, 0, 0, 0);
    send_tick(0, 0, 16384, 0, 0, 0, 65535);
    send_tick(0, 0, -16384, 0, 0, 0, 65535);
    send_tick(0, 0, 0, 16384, 0, 0, 65535);
    send_tick(0, 0, 0, -16384, 0, 0, 65535);
    send_tick(0, 0, 0, 0, 16384, 0, 65535);
    send_tick(0, 0, 0, 0, -16384, 0, 65535);
    send_tick(-1, 1, 16384, -16384, 16384, 0, 32768);
    send_tick(0, 0, 0, 0, 0, 32767, 0);        // distance hits its floor
    send_tick(0, 0, 0, 0, 0, -32768, 0);
    send_tick(1, -1, -1, -1, -1, -1, 1);
    random_ticks(140);
    drain();

    // smallest speeds, a one-degree view, orthographic
    set_camera_regs(16'd0, 16'd0, 16'd256, 1'b1);
    random_ticks(150);
    drain();

    // largest speeds; zooming out pins the distance at its ceiling
    set_camera_regs(16'hFFFF, 16'hFFFF, 16'd45824, 1'b0);
    send_tick(0, 0, 0, 0, 0, -32768, 0);
    send_tick(0, 0, 0, 0, 0, -32768, 0);
    send_tick(0, 0, 16384, 16384, 16384, 0, 65535);
    random_ticks(150);
    drain();

    // zero field of view, then half-angles at and past a right angle
    set_camera_regs(16'd7, 16'd3000, 16'd0, 1'b1);
    random_ticks(60);
    drain();
    write_reg(REG_FOV, 16'd46080);
    random_ticks(40);
    drain();
    write_reg(REG_FOV, 16'hFFFF);
    random_ticks(40);
    drain();

    set_camera_regs(16'd1280, 16'd256, 16'd15360, 1'b0);
    random_ticks(160);
    drain();

    $display("%0d ticks sent over six register settings, %0d views compared",
             ticks_sent, views_checked);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
design/ocu_pkg.sv
design/ocu_in_if.sv
design/ocu_out_if.sv
design/ocu_trig.sv
design/ocu_mul.sv
design/ocu_div.sv
design/orbit_camera_update.sv
dv/ocu_view_checker.sv
dv/tb_orbit_camera_update.sv
